FILE: rtl/tra_pkg.sv
// ----------------------------------------------------------------------------
// tra_pkg
// Widths, constants and control types shared by the tanh approximation block.
// ----------------------------------------------------------------------------
`default_nettype none

package tra_pkg;

  localparam int LANES      = 4;
  localparam int XW         = 16;
  localparam int MAG_W      = 15;
  localparam int SQ_W       = 30;
  localparam int SUM_W      = 30;
  localparam int PROD_W     = MAG_W + SUM_W;
  localparam int NUM_W      = PROD_W + 2;
  localparam int DEN_W      = 32;
  localparam int Q_W        = 15;
  localparam int DIV_STAGES = Q_W;
  localparam int STAGES     = 3 + DIV_STAGES + 1;

  localparam logic signed [XW-1:0] CLAMP_POS = 16'sd20480;
  localparam logic signed [XW-1:0] CLAMP_NEG = -16'sd20480;
  localparam logic [SUM_W-1:0]     K27      = 30'd452984832;

  typedef struct packed {
    logic [STAGES-1:0] en;
  } tra_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/tra_in_if.sv
// ----------------------------------------------------------------------------
// tra_in_if
// Input channel: four Q3.12 samples and a last flag per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface tra_in_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] x_lane0;
  logic signed [15:0] x_lane1;
  logic signed [15:0] x_lane2;
  logic signed [15:0] x_lane3;
  logic              last_in;

  modport source (output valid, x_lane0, x_lane1, x_lane2, x_lane3, last_in,
                  input ready);
  modport sink   (input valid, x_lane0, x_lane1, x_lane2, x_lane3, last_in,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/tra_out_if.sv
// ----------------------------------------------------------------------------
// tra_out_if
// Output channel: four Q1.14 results and a last flag per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface tra_out_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] y_lane0;
  logic signed [15:0] y_lane1;
  logic signed [15:0] y_lane2;
  logic signed [15:0] y_lane3;
  logic              last_out;

  modport source (output valid, y_lane0, y_lane1, y_lane2, y_lane3, last_out,
                  input ready);
  modport sink   (input valid, y_lane0, y_lane1, y_lane2, y_lane3, last_out,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/tra_ctrl.sv
// ----------------------------------------------------------------------------
// tra_ctrl
// Pipeline control: per-stage valid bits, ready chain and last flag.
// ----------------------------------------------------------------------------
`default_nettype none

module tra_ctrl import tra_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic in_last,
  input  wire logic out_ready,
  output tra_ctl_t  ctl,
  output logic      in_ready,
  output logic      out_valid,
  output logic      out_last
);

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] lst;
  logic [STAGES-1:0] rdy;

  always_comb begin
    rdy[STAGES-1] = !vld[STAGES-1] || out_ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign ctl.en    = rdy;
  assign in_ready  = rdy[0];
  assign out_valid = vld[STAGES-1];
  assign out_last  = lst[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      for (int k = 1; k < STAGES; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) lst[0] <= in_last;
    for (int k = 1; k < STAGES; k++) begin
      if (rdy[k]) lst[k] <= lst[k-1];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tra_lane.sv
// ----------------------------------------------------------------------------
// tra_lane
// One lane: clamp, square, numerator and denominator, bit-per-stage
// restoring divide, then round to nearest and restore the sign.
// ----------------------------------------------------------------------------
`default_nettype none

module tra_lane import tra_pkg::*; (
  input  wire logic                  clk,
  input  wire tra_ctl_t              ctl,
  input  wire logic signed [XW-1:0]  x,
  output logic signed [XW-1:0]       y
);

  logic signed [XW-1:0] xc;
  logic [MAG_W-1:0]     mag_c;
  logic [XW-1:0]        neg_x;

  logic [MAG_W-1:0]  mag0, mag1;
  logic              neg0, neg1;
  logic [SQ_W-1:0]   sq1;
  logic [SUM_W-1:0]  sum_c;
  logic [PROD_W-1:0] prod_c;

  logic [NUM_W-1:0] rem [0:DIV_STAGES];
  logic [Q_W-1:0]   qv  [0:DIV_STAGES];
  logic [DEN_W-1:0] dv  [0:DIV_STAGES];
  logic             ng  [0:DIV_STAGES];

  logic            rnd;
  logic [XW-1:0]   qr;

  always_comb begin
    if (x > CLAMP_POS)      xc = CLAMP_POS;
    else if (x < CLAMP_NEG) xc = CLAMP_NEG;
    else                    xc = x;
    neg_x = -xc;
    mag_c = xc[XW-1] ? neg_x[MAG_W-1:0] : xc[MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      mag0 <= mag_c;
      neg0 <= xc[XW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      sq1  <= SQ_W'(mag0) * SQ_W'(mag0);
      mag1 <= mag0;
      neg1 <= neg0;
    end
  end

  assign sum_c  = K27 + sq1;
  assign prod_c = PROD_W'(mag1) * PROD_W'(sum_c);

  always_ff @(posedge clk) begin
    if (ctl.en[2]) begin
      rem[0] <= {prod_c, 2'b00};
      dv[0]  <= DEN_W'(K27) + (DEN_W'(sq1) << 3) + DEN_W'(sq1);
      qv[0]  <= '0;
      ng[0]  <= neg1;
    end
  end

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    localparam int SH = Q_W - 1 - j;
    logic [NUM_W-1:0] dsh;
    logic             take;
    assign dsh  = NUM_W'(dv[j]) << SH;
    assign take = rem[j] >= dsh;
    always_ff @(posedge clk) begin
      if (ctl.en[3+j]) begin
        rem[j+1] <= take ? rem[j] - dsh : rem[j];
        qv[j+1]  <= qv[j] | (take ? Q_W'(1) << SH : Q_W'(0));
        dv[j+1]  <= dv[j];
        ng[j+1]  <= ng[j];
      end
    end
  end

  assign rnd = {rem[DIV_STAGES][DEN_W-1:0], 1'b0} >= {1'b0, dv[DIV_STAGES]};
  assign qr  = XW'(qv[DIV_STAGES]) + XW'(rnd);

  always_ff @(posedge clk) begin
    if (ctl.en[STAGES-1]) begin
      y <= ng[DIV_STAGES] ? -qr : qr;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tanh_rational_approx.sv
// ----------------------------------------------------------------------------
// tanh_rational_approx
// Throughput: one beat of four samples per cycle unless the output stalls,
// set by the lane pipelines (clamp, square, multiply, 15 divide stages,
// round).
// Each stage stalls only when full and blocked downstream.
// Reset clears all stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module tanh_rational_approx import tra_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  tra_in_if.sink      data_in,
  tra_out_if.source   data_out
);

  tra_ctl_t             ctl;
  logic signed [XW-1:0] xs [LANES];
  logic signed [XW-1:0] ys [LANES];

  assign xs[0] = data_in.x_lane0;
  assign xs[1] = data_in.x_lane1;
  assign xs[2] = data_in.x_lane2;
  assign xs[3] = data_in.x_lane3;

  tra_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (data_in.valid),
    .in_last   (data_in.last_in),
    .out_ready (data_out.ready),
    .ctl       (ctl),
    .in_ready  (data_in.ready),
    .out_valid (data_out.valid),
    .out_last  (data_out.last_out)
  );

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    tra_lane u_lane (
      .clk (clk),
      .ctl (ctl),
      .x   (xs[l]),
      .y   (ys[l])
    );
  end

  assign data_out.y_lane0 = ys[0];
  assign data_out.y_lane1 = ys[1];
  assign data_out.y_lane2 = ys[2];
  assign data_out.y_lane3 = ys[3];

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !data_in.ready |-> (data_out.valid && !data_out.ready))
    else $error("input stalled while pipeline has room");

  a_y_range: assert property (@(posedge clk) disable iff (rst)
    data_out.valid |-> (data_out.y_lane0 <= 16'sd16904 &&
                        data_out.y_lane0 >= -16'sd16904))
    else $error("lane 0 result out of range");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!data_out.valid && data_in.ready))
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

FILE: test/tanh_checker.sv
// ----------------------------------------------------------------------------
// tanh_checker
// Watches both channels of the tanh approximation block, computes the
// expected clamped rational tanh of every accepted input beat and compares
// each output beat with the oldest expected one.
// ----------------------------------------------------------------------------
`default_nettype none

module tanh_checker import tra_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  tra_in_if.sink    mon_in,
  tra_out_if.sink   mon_out,
  output int        fail_count,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] y0;
    logic signed [15:0] y1;
    logic signed [15:0] y2;
    logic signed [15:0] y3;
    logic               last;
  } tanh_beat_t;

  tanh_beat_t tanh_fifo[$];

  function automatic logic signed [15:0] tanh_of(logic signed [15:0] x);
    longint xs, mag, sq, num, den, q;
    xs = x;
    if (xs > 20480) xs = 20480;
    if (xs < -20480) xs = -20480;
    mag = (xs < 0) ? -xs : xs;
    sq = mag * mag;
    num = mag * 4 * (longint'(27) * 16777216 + sq);
    den = longint'(27) * 16777216 + 9 * sq;
    q = (2 * num + den) / (2 * den);
    if (xs < 0) q = -q;
    return q[15:0];
  endfunction

  assign pending = tanh_fifo.size();

  task automatic cmp(string name, logic signed [15:0] e, logic signed [15:0] a);
    if (e !== a) begin
      $error("%s: expected %0d, got %0d", name, e, a);
      fail_count++;
    end
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    tanh_beat_t e;
    if (!rst && mon_in.valid && mon_in.ready) begin
      e.y0 = tanh_of(mon_in.x_lane0);
      e.y1 = tanh_of(mon_in.x_lane1);
      e.y2 = tanh_of(mon_in.x_lane2);
      e.y3 = tanh_of(mon_in.x_lane3);
      e.last = mon_in.last_in;
      tanh_fifo.push_back(e);
    end
    if (!rst && mon_out.valid && mon_out.ready) begin
      if (tanh_fifo.size() == 0) begin
        $error("output beat with no expected beat");
        fail_count++;
      end else begin
        e = tanh_fifo.pop_front();
        cmp("y_lane0", e.y0, mon_out.y_lane0);
        cmp("y_lane1", e.y1, mon_out.y_lane1);
        cmp("y_lane2", e.y2, mon_out.y_lane2);
        cmp("y_lane3", e.y3, mon_out.y_lane3);
        if (e.last !== mon_out.last_out) begin
          $error("last_out: expected %0d, got %0d", e.last, mon_out.last_out);
          fail_count++;
        end
      end
    end
  end
endmodule

`default_nettype wire

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random sample beats into the tanh approximation block
// with random gaps and back-pressure, and reports the checker's verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import tra_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count, pending;
  int   send_idle, recv_idle;

  tra_in_if  data_in();
  tra_out_if data_out();

  tanh_rational_approx i_dut (.clk(clk), .rst(rst), .data_in(data_in), .data_out(data_out));
  tanh_checker i_chk (.clk(clk), .rst(rst), .mon_in(data_in), .mon_out(data_out),
                      .fail_count(fail_count), .pending(pending));

  always #4 clk = ~clk;

  initial begin
    data_in.valid = 1'b0;
    data_in.x_lane0 = '0;
    data_in.x_lane1 = '0;
    data_in.x_lane2 = '0;
    data_in.x_lane3 = '0;
    data_in.last_in = 1'b0;
    data_out.ready = 1'b0;
  end

  always @(posedge clk)
    data_out.ready <= !rst && ($urandom_range(99) >= recv_idle);

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(40960)) - 16'sd20480;
      2: return 16'($urandom_range(1000)) - 16'sd500;
      default: return $urandom_range(1) ? 16'sd20480 + 16'($urandom_range(3)) - 16'sd1
                                          : -16'sd20480 + 16'($urandom_range(3)) - 16'sd1;
    endcase
  endfunction

  task automatic send_beat(logic signed [15:0] a, b, c, d, logic last);
    while ($urandom_range(99) < send_idle) begin
      data_in.valid <= 1'b0;
      @(posedge clk);
    end
    data_in.valid   <= 1'b1;
    data_in.x_lane0 <= a;
    data_in.x_lane1 <= b;
    data_in.x_lane2 <= c;
    data_in.x_lane3 <= d;
    data_in.last_in <= last;
    @(posedge clk);
    while (!data_in.ready) @(posedge clk);
  endtask

  task automatic send_random(int n);
    for (int i = 0; i < n; i++)
      send_beat(rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                $urandom_range(1));
  endtask

  initial begin
    send_idle = 0;
    recv_idle = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_beat(16'sd0, 16'sd1, -16'sd1, 16'sd4096, 1'b0);
    send_beat(16'sh7fff, 16'sh8000, 16'sd20480, -16'sd20480, 1'b1);
    send_beat(16'sd20481, -16'sd20481, 16'sd20479, -16'sd20479, 1'b0);
    send_beat(-16'sd4096, 16'sd8192, -16'sd8192, 16'sd2048, 1'b1);
    send_beat(16'sh5555, 16'shaaaa, 16'sh00ff, 16'shff00, 1'b0);
    send_beat(16'sd12288, -16'sd12288, 16'sd16384, -16'sd16384, 1'b1);
    send_idle = 28;
    recv_idle = 57;
    send_random(215);
    send_idle = 57;
    recv_idle = 28;
    send_random(215);
    send_idle = 0;
    recv_idle = 0;
    send_random(215);
    data_in.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule

`default_nettype wire
